>>> design/bsle_pkg.sv
// Shared types and constants for the bounded sequence list engine.
// Used by the sequencer, the top level and the testbench; depends on nothing.
package bsle_pkg;

  localparam int BSLE_DEPTH_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int POS_W          = 5;
  localparam int CNT_OUT_W      = 5;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT_AT  = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_DELETE_AT  = 3'd5,
    REQ_DELETE_VAL = 3'd6,
    REQ_DUMP       = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_FLT_RD,
    S_FLT_WR,
    S_DMP_RD,
    S_DMP_OUT,
    S_STATUS
  } state_t;

  // one result from the sequencer toward the output register
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic [CNT_OUT_W-1:0]     count;
    logic                     last;
  } res_t;

endpackage

>>> design/bsle_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/bsle_seq.sv
// Request sequencer: decodes a request, then walks the entry RAM one entry
// at a time, a read state followed by a write state, with a shared index/compare unit. Depends on bsle_pkg.
module bsle_seq import bsle_pkg::*; #(
  parameter int DEPTH = BSLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  req_t                     req,
  input  logic signed [DATA_W-1:0] value,
  input  logic [POS_W-1:0]         position,
  output res_t                     res,
  input  logic                     res_ready,
  output logic [$clog2(DEPTH+1)-1:0] fill,
  output logic                     ram_wr_en,
  output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
  output logic [DATA_W-1:0]        ram_wr_data,
  output logic                     ram_rd_en,
  output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
  input  logic signed [DATA_W-1:0] ram_rd_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  status_t                  st, st_next;
  logic signed [DATA_W-1:0] val, val_next;
  logic [CW-1:0]            idx, idx_next;
  logic [CW-1:0]            ptr, ptr_next;
  logic [CW-1:0]            wptr, wptr_next;
  logic                     delval, delval_next;

  logic [CW-1:0]   ptr_m1, ptr_p1;
  logic [CMPW-1:0] pos_x, cnt_x;
  logic            full, empty, keep;

  assign ptr_m1 = ptr - CW'(1);
  assign ptr_p1 = ptr + CW'(1);
  assign pos_x  = CMPW'(position);
  assign cnt_x  = CMPW'(count);
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign keep   = delval ? (ram_rd_data != val) : (ptr != idx);
  assign fill   = count;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    st     <= st_next;
    val    <= val_next;
    idx    <= idx_next;
    ptr    <= ptr_next;
    wptr   <= wptr_next;
    delval <= delval_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    st_next     = st;
    val_next    = val;
    idx_next    = idx;
    ptr_next    = ptr;
    wptr_next   = wptr;
    delval_next = delval;
    ram_wr_en   = 1'b0;
    ram_wr_addr = wptr[AW-1:0];
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr[AW-1:0];
    res.valid   = 1'b0;
    res.data    = '0;
    res.status  = st;
    res.count   = CNT_OUT_W'(count);
    res.last    = 1'b1;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          st_next     = ST_OK;
          val_next    = value;
          delval_next = 1'b0;
          ptr_next    = count;
          state_next  = S_STATUS;
          case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (full) begin
                st_next = ST_FULL;
              end else begin
                idx_next   = (req == REQ_PUSH_FRONT) ? '0 : count;
                state_next = S_INS_RD;
              end
            end
            REQ_INSERT_AT: begin
              if (full) begin
                st_next = ST_FULL;
              end else if (position == '0 || pos_x > cnt_x + CMPW'(1)) begin
                st_next = ST_RANGE;
              end else begin
                idx_next   = CW'(pos_x - CMPW'(1));
                state_next = S_INS_RD;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else begin
                idx_next   = (req == REQ_POP_FRONT) ? '0 : count - CW'(1);
                ptr_next   = idx_next;
                wptr_next  = idx_next;
                state_next = S_FLT_RD;
              end
            end
            REQ_DELETE_AT: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else if (position == '0 || pos_x > cnt_x) begin
                st_next = ST_RANGE;
              end else begin
                idx_next   = CW'(pos_x - CMPW'(1));
                ptr_next   = idx_next;
                wptr_next  = idx_next;
                state_next = S_FLT_RD;
              end
            end
            REQ_DELETE_VAL: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else begin
                delval_next = 1'b1;
                ptr_next    = '0;
                wptr_next   = '0;
                state_next  = S_FLT_RD;
              end
            end
            default: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else begin
                ptr_next   = '0;
                state_next = S_DMP_RD;
              end
            end
          endcase
        end
      end

      // open a gap: move entries up from the tail down to the insert point
      S_INS_RD: begin
        if (ptr > idx) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ptr_m1[AW-1:0];
          state_next  = S_INS_WR;
        end else begin
          state_next = S_INS_PUT;
        end
      end

      S_INS_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = ptr[AW-1:0];
        ptr_next    = ptr_m1;
        state_next  = S_INS_RD;
      end

      S_INS_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx[AW-1:0];
        ram_wr_data = val;
        count_next  = count + CW'(1);
        state_next  = S_STATUS;
      end

      // compacting pass: copy kept entries down, skip the removed ones
      S_FLT_RD: begin
        if (ptr < count) begin
          ram_rd_en  = 1'b1;
          state_next = S_FLT_WR;
        end else begin
          count_next = wptr;
          state_next = S_STATUS;
        end
      end

      S_FLT_WR: begin
        if (keep) begin
          ram_wr_en = 1'b1;
          wptr_next = wptr + CW'(1);
        end
        ptr_next   = ptr_p1;
        state_next = S_FLT_RD;
      end

      S_DMP_RD: begin
        ram_rd_en  = 1'b1;
        state_next = S_DMP_OUT;
      end

      S_DMP_OUT: begin
        res.valid  = 1'b1;
        res.data   = ram_rd_data;
        res.status = ST_OK;
        res.last   = (ptr_p1 == count);
        if (res_ready) begin
          ptr_next   = ptr_p1;
          state_next = (ptr_p1 == count) ? S_IDLE : S_DMP_RD;
        end
      end

      S_STATUS: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/bounded_sequence_list_engine_unit.sv
// Top level of the bounded sequence list engine: stream ports, entry RAM,
// request sequencer and output register. Depends on bsle_pkg, bsle_ram, bsle_seq.
//
// Keeps an ordered list of up to DEPTH signed 32-bit entries in one RAM and
// serves one request at a time; s_axis_tready is low while a request is in
// work. Rejected requests and dumps of an empty list go straight to a status
// transaction. Pushes, inserts, pops and deletes move entries one at a time
// through the single RAM read/write port pair. A dump streams its entries one
// by one, fetching the next once the output register takes the last. Every
// request except a non-empty dump gives one status transaction with tlast set;
// a dump gives one transaction per entry, tlast on the final one. No clearing
// pass is needed after reset.
module bounded_sequence_list_engine_unit import bsle_pkg::*; #(
  parameter int DEPTH = BSLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type [2:0], value [34:3], position [39:35]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_out [31:0], status [33:32], entry_count [38:34], zero [39]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t                     res;
  logic                     res_ready;
  logic [CW-1:0]            fill;
  logic                     ram_wr_en, ram_rd_en;
  logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
  logic [DATA_W-1:0]        ram_wr_data, ram_rd_data;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  status_t                  out_status;
  logic [CNT_OUT_W-1:0]     out_count;
  logic                     out_last;

  bsle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  bsle_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .req         (req_t'(s_axis_tdata[2:0])),
    .value       (s_axis_tdata[34:3]),
    .position    (s_axis_tdata[39:35]),
    .res         (res),
    .res_ready   (res_ready),
    .fill        (fill),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // output register frees the sequencer once a result is handed over
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_data   <= res.data;
      out_status <= res.status;
      out_count  <= res.count;
      out_last   <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_status, out_data};
  assign m_axis_tlast  = out_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in work");

  a_midframe_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[33:32] == ST_OK)
    else $error("non-final dump transaction with error status");

  a_midframe_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> fill != '0)
    else $error("dump transaction with empty list");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for bounded_sequence_list_engine_unit: a directed table, then random
// fill, drain and mixed request sequences, all checked against a list predictor.
// Depends on bsle_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb import bsle_pkg::*; ();

  localparam int DEPTH      = BSLE_DEPTH_DEF;
  localparam int TOTAL_REQS = 330;
  localparam int CALM_TAIL  = 40;

  typedef struct packed {
    logic signed [31:0] data;
    status_t            st;
    logic [4:0]         cnt;
    logic               last;
  } list_result_t;

  typedef struct packed {
    req_t               req;
    logic signed [31:0] val;
    logic [4:0]         pos;
    logic               typed;
    status_t            st;
    logic [4:0]         cnt;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  logic signed [31:0] list_mem [DEPTH];
  int                 list_len = 0;
  list_result_t       result_q [$];
  plan_row_t          plan [$];

  int  errors = 0;
  int  sent = 0;
  int  checked = 0;
  int  full_rejects = 0;
  int  dumps = 0;
  bit  calm = 1'b0;

  bounded_sequence_list_engine_unit #(.DEPTH(DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, result_q.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void place(int idx, logic signed [31:0] v);
    for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = v;
    list_len++;
  endfunction

  function automatic void drop(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endfunction

  function automatic void apply_request(req_t req, logic signed [31:0] val, logic [4:0] pos);
    status_t st;
    int      j;
    st = ST_OK;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else place((req == REQ_PUSH_FRONT) ? 0 : list_len, val);
      end
      REQ_INSERT_AT: begin
        // full wins over a bad position
        if (list_len >= DEPTH) st = ST_FULL;
        else if (pos < 1 || pos > list_len + 1) st = ST_RANGE;
        else place(pos - 1, val);
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else drop((req == REQ_POP_FRONT) ? 0 : list_len - 1);
      end
      REQ_DELETE_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (pos < 1 || pos > list_len) st = ST_RANGE;
        else drop(pos - 1);
      end
      REQ_DELETE_VAL: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          j = 0;
          for (int i = 0; i < list_len; i++)
            if (list_mem[i] != val) begin
              list_mem[j] = list_mem[i];
              j++;
            end
          list_len = j;
        end
      end
      default: begin
        dumps++;
        if (list_len == 0) result_q.insert(result_q.size(), '{32'sd0, ST_EMPTY, 5'd0, 1'b1});
        else
          for (int i = 0; i < list_len; i++)
            result_q.insert(result_q.size(),
                            '{list_mem[i], ST_OK, 5'(list_len), 1'(i + 1 == list_len)});
        return;
      end
    endcase
    if (st == ST_FULL) full_rejects++;
    result_q.insert(result_q.size(), '{32'sd0, st, 5'(list_len), 1'b1});
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // drives one request and returns at the edge where it is taken
  task automatic send_req(input req_t req, input logic signed [31:0] val, input logic [4:0] pos);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 40'({$urandom, $urandom});
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, val, req};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_request(req, val, pos);
    sent++;
    calm = (sent >= TOTAL_REQS - CALM_TAIL);
  endtask

  task automatic add_row(input req_t req, input logic signed [31:0] val, input logic [4:0] pos,
                         input logic typed, input status_t st, input logic [4:0] cnt);
    plan.insert(plan.size(), '{req, val, pos, typed, st, cnt});
  endtask

  // ---------------------------------------------------------------- output side

  initial begin
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, data %h status %0d count %0d last %b",
                 $time, m_axis_tdata[31:0], m_axis_tdata[33:32], m_axis_tdata[38:34],
                 m_axis_tlast);
      end else begin
        want = result_q.pop_front();
        checked++;
        if (m_axis_tdata[31:0] !== want.data) begin
          errors++;
          $display("%0t: data_out expected %h, got %h", $time, want.data, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[33:32] !== want.st) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time, want.st, m_axis_tdata[33:32]);
        end
        if (m_axis_tdata[38:34] !== want.cnt) begin
          errors++;
          $display("%0t: entry_count expected %0d, got %0d", $time, want.cnt,
                   m_axis_tdata[38:34]);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: tlast expected %b, got %b", $time, want.last, m_axis_tlast);
        end
        if (m_axis_tdata[39] !== 1'b0) begin
          errors++;
          $display("%0t: tdata pad bit expected 0, got %b", $time, m_axis_tdata[39]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    int   n;
    int   mode;
    bit   first;
    req_t r;
    logic signed [31:0] v;
    logic [4:0] p;

    // empty list rejections
    add_row(REQ_DUMP,       0, 0, 1, ST_EMPTY, 0);
    add_row(REQ_POP_FRONT,  0, 0, 1, ST_EMPTY, 0);
    add_row(REQ_POP_BACK,   0, 0, 1, ST_EMPTY, 0);
    add_row(REQ_DELETE_AT,  0, 1, 1, ST_EMPTY, 0);
    add_row(REQ_DELETE_VAL, 0, 0, 1, ST_EMPTY, 0);
    add_row(REQ_INSERT_AT,  1, 0, 1, ST_RANGE, 0);
    add_row(REQ_INSERT_AT,  1, 2, 1, ST_RANGE, 0);
    // value extremes and positions at both ends
    add_row(REQ_PUSH_FRONT, 32'sh7fffffff, 0, 1, ST_OK, 1);
    add_row(REQ_PUSH_BACK,  32'sh80000000, 31, 1, ST_OK, 2);
    add_row(REQ_INSERT_AT,  -1, 3, 1, ST_OK, 3);
    add_row(REQ_INSERT_AT,  5, 1, 1, ST_OK, 4);
    add_row(REQ_DELETE_AT,  0, 0, 1, ST_RANGE, 4);
    add_row(REQ_DELETE_AT,  0, 5, 1, ST_RANGE, 4);
    add_row(REQ_INSERT_AT,  7, 31, 1, ST_RANGE, 4);
    add_row(REQ_DUMP,       0, 0, 0, ST_OK, 0);
    // duplicates at head, middle and tail, then remove them all
    add_row(REQ_PUSH_BACK,  5, 0, 1, ST_OK, 5);
    add_row(REQ_INSERT_AT,  5, 3, 1, ST_OK, 6);
    add_row(REQ_DELETE_VAL, 5, 0, 1, ST_OK, 3);
    add_row(REQ_DELETE_VAL, 1234, 0, 1, ST_OK, 3);
    add_row(REQ_DUMP,       0, 0, 0, ST_OK, 0);
    add_row(REQ_DELETE_AT,  0, 3, 1, ST_OK, 2);
    add_row(REQ_POP_FRONT,  0, 0, 1, ST_OK, 1);
    add_row(REQ_POP_BACK,   0, 0, 1, ST_OK, 0);
    add_row(REQ_DUMP,       0, 0, 1, ST_EMPTY, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_req(plan[i].req, plan[i].val, plan[i].pos);
      if (plan[i].typed) begin
        result_q[$] = '{32'sd0, plan[i].st, plan[i].cnt, 1'b1};
      end
    end

    first = 1'b1;
    while (sent < TOTAL_REQS) begin
      mode  = first ? 0 : $urandom_range(0, 9);
      first = 1'b0;
      if (mode <= 2) begin
        // fill to the top, then knock on a full list
        while (list_len < DEPTH) begin
          r = req_t'($urandom_range(REQ_PUSH_FRONT, REQ_INSERT_AT));
          send_req(r, pick_value(), 5'($urandom_range(1, list_len + 1)));
        end
        repeat ($urandom_range(1, 3))
          send_req(req_t'($urandom_range(REQ_PUSH_FRONT, REQ_INSERT_AT)), pick_value(),
                   5'($urandom_range(0, 31)));
        if ($urandom_range(0, 1) == 0) send_req(REQ_DUMP, pick_value(), 5'($urandom));
      end else if (mode <= 4) begin
        // drain to empty, then hit the empty cases
        while (list_len > 0) begin
          r = req_t'($urandom_range(REQ_POP_FRONT, REQ_DELETE_VAL));
          v = (r == REQ_DELETE_VAL) ? list_mem[$urandom_range(0, list_len - 1)] : pick_value();
          send_req(r, v, 5'($urandom_range(1, list_len)));
        end
        repeat ($urandom_range(1, 2))
          send_req(req_t'($urandom_range(REQ_POP_FRONT, REQ_DUMP)), pick_value(),
                   5'($urandom_range(0, 31)));
      end else if (mode <= 8) begin
        n = $urandom_range(4, 10);
        repeat (n) begin
          r = req_t'($urandom_range(0, 7));
          v = pick_value();
          if (r == REQ_DELETE_VAL && list_len > 0 && $urandom_range(0, 1) == 0)
            v = list_mem[$urandom_range(0, list_len - 1)];
          if ($urandom_range(0, 1) == 0) p = 5'($urandom_range(0, 31));
          else p = 5'($urandom_range(1, list_len + 1));
          send_req(r, v, p);
        end
      end else begin
        send_req(REQ_DUMP, pick_value(), 5'($urandom));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);

    $display("%0d requests sent (%0d from the directed table), %0d dumps", sent, plan.size(),
             dumps);
    $display("%0d result transactions checked, %0d pushes or inserts refused on a full list",
             checked, full_rejects);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
